/* rtl/core/cmr_pkg.sv */
package cmr_pkg;

    localparam int unsigned COMPONENT_BITS_DEF = 16;
    localparam int unsigned FRACTION_BITS_DEF  = 8;
    localparam int unsigned OUT_BITS           = 24;
    localparam int unsigned QUEUE_DEPTH        = 4;

    // flags carried with an item from the front end to the back end
    typedef struct packed {
        logic zero_den;
        logic num_zero;
    } t_item_flags;

endpackage

/* rtl/core/cmr_front.sv */
module cmr_front #(
    parameter int unsigned COMPONENT_BITS = cmr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_num_re,
    input  logic signed [COMPONENT_BITS-1:0] i_num_im,
    input  logic signed [COMPONENT_BITS-1:0] i_den_re,
    input  logic signed [COMPONENT_BITS-1:0] i_den_im,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [2*COMPONENT_BITS:0]        o_num_pow,
    output logic [2*COMPONENT_BITS:0]        o_den_pow,
    output cmr_pkg::t_item_flags             o_flags
);
    import cmr_pkg::*;

    localparam int unsigned PW = 2 * COMPONENT_BITS + 1;
    localparam int unsigned SQ = 2 * COMPONENT_BITS;

    logic [COMPONENT_BITS-1:0] a_nr, a_ni, a_dr, a_di;
    logic [SQ-1:0]             e_nr, e_ni, e_dr, e_di;
    logic                      adv;
    logic                      r_valid;
    logic [PW-1:0]             r_num_pow, r_den_pow;

    // magnitudes of the parts; the most negative value keeps its bit pattern
    assign a_nr = i_num_re[COMPONENT_BITS-1] ? -i_num_re : i_num_re;
    assign a_ni = i_num_im[COMPONENT_BITS-1] ? -i_num_im : i_num_im;
    assign a_dr = i_den_re[COMPONENT_BITS-1] ? -i_den_re : i_den_re;
    assign a_di = i_den_im[COMPONENT_BITS-1] ? -i_den_im : i_den_im;

    // widen before squaring so the products keep every bit
    assign e_nr = SQ'(a_nr);
    assign e_ni = SQ'(a_ni);
    assign e_dr = SQ'(a_dr);
    assign e_di = SQ'(a_di);

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    // power of numerator and denominator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
        if (adv && i_valid) begin
            r_num_pow <= PW'(e_nr * e_nr) + PW'(e_ni * e_ni);
            r_den_pow <= PW'(e_dr * e_dr) + PW'(e_di * e_di);
        end
    end

    assign o_valid   = r_valid;
    assign o_num_pow = r_num_pow;
    assign o_den_pow = r_den_pow;
    assign o_flags   = '{zero_den: (r_den_pow == '0), num_zero: (r_num_pow == '0)};

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_den_pow))
        else $error("front held item changed under stall");
endmodule

/* rtl/core/cmr_queue.sv */
module cmr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = cmr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);
    import cmr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             wr, rd;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_valid && !o_stall;
    assign rd      = o_valid && !i_stall;
    assign o_data  = r_mem[r_rp];

    // storage and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count past depth");
endmodule

/* rtl/core/cmr_back.sv */
module cmr_back #(
    parameter int unsigned COMPONENT_BITS = cmr_pkg::COMPONENT_BITS_DEF,
    parameter int unsigned FRACTION_BITS  = cmr_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2*COMPONENT_BITS:0]     i_num_pow,
    input  logic [2*COMPONENT_BITS:0]     i_den_pow,
    input  cmr_pkg::t_item_flags          i_flags,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cmr_pkg::OUT_BITS-1:0]  o_magnitude_ratio,
    output logic                          o_zero_denominator
);
    import cmr_pkg::*;

    localparam int unsigned PW  = 2 * COMPONENT_BITS + 1;
    localparam int unsigned QB  = 2 * OUT_BITS;           // quotient bits kept
    localparam int unsigned RW  = PW + 1;                 // remainder width
    // numerator scaled by 2^(2F); quotient bits above QB are saturation
    localparam int unsigned SW  = PW + 2 * FRACTION_BITS;
    localparam int unsigned NS  = SW;                     // division stages
    localparam int unsigned SS  = OUT_BITS;               // root stages
    localparam int unsigned NST = NS + SS;

    logic adv;
    logic [NST:0] r_v;
    assign adv     = !r_v[NST] || !i_stall;
    assign o_stall = !adv;

    // pipeline valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-1:0], i_valid};
        end
    end

    // division stages: one quotient bit per stage, one per scaled numerator bit
    logic [SW-1:0] r_dn  [NS+1];
    logic [PW-1:0] r_dd  [NS+1];
    logic [RW-1:0] r_rem [NS+1];
    logic [QB-1:0] r_q   [NS+1];
    logic          r_sat [NST+1];
    logic          r_zd  [NST+1];

    // entry: scaled numerator, divisor and flags
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dn[0]  <= SW'(i_num_pow) << (2 * FRACTION_BITS);
            r_dd[0]  <= i_den_pow;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_sat[0] <= 1'b0;
            r_zd[0]  <= i_flags.zero_den;
        end
    end

    // a one shifted out of the top quotient bit means saturation
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_div
            logic [RW-1:0] rem;
            logic [QB-1:0] q;
            logic          sat;
            always_comb begin
                rem = {r_rem[g][RW-2:0], r_dn[g][SW-1]};
                sat = r_sat[g] | r_q[g][QB-1];
                q   = {r_q[g][QB-2:0], 1'b0};
                if (rem >= RW'(r_dd[g])) begin
                    rem  = rem - RW'(r_dd[g]);
                    q[0] = 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rem[g+1] <= rem;
                    r_q[g+1]   <= q;
                    r_dn[g+1]  <= {r_dn[g][SW-2:0], 1'b0};
                    r_dd[g+1]  <= r_dd[g];
                    r_sat[g+1] <= sat;
                    r_zd[g+1]  <= r_zd[g];
                end
            end
        end
    endgenerate

    // square root stages: one result bit per stage, running square kept
    logic [QB-1:0]       r_rq  [1:SS];
    logic [OUT_BITS-1:0] r_res [1:SS];
    logic [QB-1:0]       r_sq  [1:SS];

    generate
        for (g = 0; g < SS; g++) begin : g_sqrt
            localparam int unsigned B = SS - 1 - g;
            logic [QB-1:0]       rq;
            logic [OUT_BITS-1:0] base;
            logic [QB-1:0]       base_sq;
            logic [OUT_BITS-1:0] t;
            logic [QB-1:0]       tt;
            if (g == 0) begin : g_first
                assign rq      = r_q[NS];
                assign base    = '0;
                assign base_sq = '0;
            end else begin : g_rest
                assign rq      = r_rq[g];
                assign base    = r_res[g];
                assign base_sq = r_sq[g];
            end
            // (base + 2^B)^2 from the running square, adds only
            assign t  = base | (OUT_BITS'(1) << B);
            assign tt = base_sq + (QB'(base) << (B + 1)) + (QB'(1) << (2 * B));
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rq[g+1]     <= rq;
                    r_res[g+1]    <= (tt <= rq) ? t : base;
                    r_sq[g+1]     <= (tt <= rq) ? tt : base_sq;
                    r_sat[NS+g+1] <= r_sat[NS+g];
                    r_zd[NS+g+1]  <= r_zd[NS+g];
                end
            end
        end
    endgenerate

    assign o_valid            = r_v[NST];
    assign o_magnitude_ratio  = (r_zd[NST] || r_sat[NST]) ? '1 : r_res[SS];
    assign o_zero_denominator = r_zd[NST];

    a_zd_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_denominator |-> (o_magnitude_ratio == '1))
        else $error("zero denominator without saturated result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");
endmodule

/* rtl/core/complex_magnitude_ratio_unit.sv */
// complex magnitude ratio: |num|/|den| per frequency bin, 8 fraction bits
// pipeline: front power register, queue, then divide stages and 24 root stages
// throughput: one item per cycle while the output does not stall; the divider and root are fully pipelined
// stall from the output freezes the back pipe; the queue decouples the front
// reset (synchronous, active low) clears valid state; payload is not reset
module complex_magnitude_ratio_unit #(
    parameter int unsigned COMPONENT_BITS = cmr_pkg::COMPONENT_BITS_DEF,
    parameter int unsigned FRACTION_BITS  = cmr_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_num_re,
    input  logic signed [COMPONENT_BITS-1:0] i_num_im,
    input  logic signed [COMPONENT_BITS-1:0] i_den_re,
    input  logic signed [COMPONENT_BITS-1:0] i_den_im,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [cmr_pkg::OUT_BITS-1:0]     o_magnitude_ratio,
    output logic                             o_zero_denominator
);
    import cmr_pkg::*;

    localparam int unsigned PW = 2 * COMPONENT_BITS + 1;
    localparam int unsigned QW = 2 * PW + $bits(t_item_flags);

    logic          f_valid, f_stall, b_valid, b_stall;
    logic [PW-1:0] f_num, f_den, b_num, b_den;
    t_item_flags   f_flags, b_flags;

    // front: powers of both values
    cmr_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_num_re, .i_num_im, .i_den_re, .i_den_im,
        .o_valid(f_valid), .i_stall(f_stall),
        .o_num_pow(f_num), .o_den_pow(f_den), .o_flags(f_flags)
    );

    // queue between front and back
    cmr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall), .i_data({f_num, f_den, f_flags}),
        .o_valid(b_valid), .i_stall(b_stall), .o_data({b_num, b_den, b_flags})
    );

    // back: pipelined divide and square root
    cmr_back #(.COMPONENT_BITS(COMPONENT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_stall(b_stall),
        .i_num_pow(b_num), .i_den_pow(b_den), .i_flags(b_flags),
        .o_valid, .i_stall, .o_magnitude_ratio, .o_zero_denominator
    );
endmodule
